// File: hw/rtl/lmfb_pkg.sv
package lmfb_pkg;

  localparam int NUM_DEVICES = 4;
  localparam int ROW_W       = 8 * NUM_DEVICES;
  localparam int COL_W       = $clog2(ROW_W);
  localparam int DEV_W       = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int NUM_ROWS    = 8;
  localparam int ROW_AW      = 3;
  localparam int FRAME_W     = 64;
  localparam int CFG_AW      = 8;
  localparam int CFG_DW      = 8;
  localparam int STEP_W      = 3;

  localparam logic [CFG_AW-1:0] CFG_INTENSITY  = 8'd0;
  localparam logic [CFG_AW-1:0] CFG_SCAN_LIMIT = 8'd1;

  localparam logic [7:0] ADDR_TEST      = 8'h0F;
  localparam logic [7:0] ADDR_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] ADDR_SCAN      = 8'h0B;
  localparam logic [7:0] ADDR_INTENSITY = 8'h0A;
  localparam logic [7:0] ADDR_DECODE    = 8'h09;
  localparam logic [7:0] DATA_NORMAL_OP = 8'h01;

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_PIXEL   = 2'd2,
    MODE_REFRESH = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    INIT_TEST      = 3'd0,
    INIT_SHUTDOWN  = 3'd1,
    INIT_SCAN      = 3'd2,
    INIT_INTENSITY = 3'd3,
    INIT_DECODE    = 3'd4
  } init_reg_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT_EMIT,
    OP_CLEAR,
    OP_ROW_EMIT,
    OP_PIX_RD,
    OP_PIX_WR
  } op_e;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_GOTO,
    JC_DONE,
    JC_DISPATCH
  } jump_e;

  localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] S_INIT   = 3'd1;
  localparam logic [STEP_W-1:0] S_CLR_RF = 3'd2;
  localparam logic [STEP_W-1:0] S_ROW    = 3'd3;
  localparam logic [STEP_W-1:0] S_PRD    = 3'd4;
  localparam logic [STEP_W-1:0] S_PWR    = 3'd5;
  localparam logic [STEP_W-1:0] S_CLR    = 3'd6;

  typedef struct packed {
    op_e               op;
    jump_e             jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic accept;
  } ctrl_t;

  typedef struct packed {
    mode_e      mode;
    logic [5:0] pixel_x;
    logic [3:0] pixel_y;
    logic       pixel_on;
  } in_word_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               last;
  } out_word_t;

  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '{op: OP_IDLE, jc: JC_DISPATCH, target: S_IDLE};
    unique case (step)
      S_IDLE:   cw = '{op: OP_IDLE,      jc: JC_DISPATCH, target: S_IDLE};
      S_INIT:   cw = '{op: OP_INIT_EMIT, jc: JC_DONE,     target: S_CLR_RF};
      S_CLR_RF: cw = '{op: OP_CLEAR,     jc: JC_NEXT,     target: S_ROW};
      S_ROW:    cw = '{op: OP_ROW_EMIT,  jc: JC_DONE,     target: S_IDLE};
      S_PRD:    cw = '{op: OP_PIX_RD,    jc: JC_NEXT,     target: S_PWR};
      S_PWR:    cw = '{op: OP_PIX_WR,    jc: JC_GOTO,     target: S_IDLE};
      S_CLR:    cw = '{op: OP_CLEAR,     jc: JC_GOTO,     target: S_IDLE};
      default:  cw = '{op: OP_IDLE,      jc: JC_GOTO,     target: S_IDLE};
    endcase
    return cw;
  endfunction

  function automatic logic [7:0] init_addr(init_reg_e idx);
    logic [7:0] a;
    a = 8'h00;
    unique case (idx)
      INIT_TEST:      a = ADDR_TEST;
      INIT_SHUTDOWN:  a = ADDR_SHUTDOWN;
      INIT_SCAN:      a = ADDR_SCAN;
      INIT_INTENSITY: a = ADDR_INTENSITY;
      INIT_DECODE:    a = ADDR_DECODE;
      default:        a = 8'h00;
    endcase
    return a;
  endfunction

endpackage

// File: hw/rtl/lmfb_store.sv
module lmfb_store import lmfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic [ROW_AW-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic [ROW_AW-1:0] wr_addr_i,
  input  logic [ROW_W-1:0]  wr_data_i,
  output logic [ROW_W-1:0]  rd_data_o
);

  logic [ROW_W-1:0]    mem_q [NUM_ROWS];
  logic [NUM_ROWS-1:0] valid_q, valid_d;
  logic [ROW_W-1:0]    rd_q;
  logic                rd_ok_q, rd_ok_d;

  always_comb begin
    valid_d = valid_q;
    if (clr_i) begin
      valid_d = '0;
    end
    if (wr_en_i) begin
      valid_d[wr_addr_i] = 1'b1;
    end
    rd_ok_d = valid_q[rd_addr_i] & ~clr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

// File: hw/rtl/lmfb_seq.sv
module lmfb_seq import lmfb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_word_t in_word_i,
  input  logic     done_i,
  output ctrl_t    ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            cw;
  logic              pix_ok;

  always_comb begin
    cw     = ucode_rom(step_q);
    pix_ok = (7'(in_word_i.pixel_x) < 7'(ROW_W)) && !in_word_i.pixel_y[3];
    ctrl_o.op     = cw.op;
    ctrl_o.accept = (cw.op == OP_IDLE) && in_valid_i;
    step_d = step_q;
    unique case (cw.jc)
      JC_NEXT: step_d = step_q + 1'b1;
      JC_GOTO: step_d = cw.target;
      JC_DONE: begin
        if (done_i) begin
          step_d = cw.target;
        end
      end
      JC_DISPATCH: begin
        if (in_valid_i) begin
          unique case (in_word_i.mode)
            MODE_INIT:    step_d = S_INIT;
            MODE_CLEAR:   step_d = S_CLR;
            MODE_PIXEL:   step_d = pix_ok ? S_PRD : S_IDLE;
            MODE_REFRESH: step_d = S_ROW;
            default:      step_d = S_IDLE;
          endcase
        end
      end
      default: step_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: hw/rtl/led_matrix_frame_buffer_refresh_unit.sv
// Init gives 5*NUM_DEVICES set-up frames, one clear step and 8 row frames, the frames
//   emitted one per cycle while the output is not stalled; refresh gives 8 frames;
//   set pixel steps through read, write and back to idle; clear clears, then idles.
// Throughput is set by the single output register: one frame per cycle when drained.
// Reset clears the pixel store (per-row valid bits), sets intensity 0, scan limit 7.
module led_matrix_frame_buffer_refresh_unit import lmfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  ctrl_t ctrl;
  logic  done;

  logic [3:0]        intensity_q;
  logic [2:0]        scan_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_AW-1:0] py_q;
  logic              on_q;
  logic [DEV_W-1:0]  dev_q, dev_d;
  init_reg_e         reg_q, reg_d;
  logic [ROW_AW-1:0] row_q, row_d;
  logic              ovalid_q, ovalid_d;
  out_word_t         oword_q, oword_d;

  logic              emit_ok;
  logic [ROW_AW-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;
  logic [ROW_W-1:0]  wr_data;
  logic [7:0]        init_data;
  logic [FRAME_W-1:0] init_frame, row_frame;

  lmfb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .done_i     (done),
    .ctrl_o     (ctrl)
  );

  lmfb_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (ctrl.op == OP_CLEAR),
    .rd_addr_i (rd_addr),
    .wr_en_i   (ctrl.op == OP_PIX_WR),
    .wr_addr_i (py_q),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  assign in_ready_o  = (ctrl.op == OP_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign out_word_o  = oword_q;
  assign emit_ok     = !ovalid_q || out_ready_i;

  always_comb begin
    case (reg_q)
      INIT_SHUTDOWN:  init_data = DATA_NORMAL_OP;
      INIT_SCAN:      init_data = {5'd0, scan_q};
      INIT_INTENSITY: init_data = {4'd0, intensity_q};
      default:        init_data = 8'h00;
    endcase
    init_frame = '0;
    row_frame  = '0;
    for (int s = 0; s < NUM_DEVICES; s++) begin
      if (DEV_W'(NUM_DEVICES - 1 - s) == dev_q) begin
        init_frame[FRAME_W-1-16*s -: 8] = init_addr(reg_q);
        init_frame[FRAME_W-9-16*s -: 8] = init_data;
      end
      row_frame[FRAME_W-1-16*s -: 8] = 8'(row_q) + 8'd1;
      row_frame[FRAME_W-9-16*s -: 8] = rd_data[8*(NUM_DEVICES-1-s) +: 8];
    end
    wr_data        = rd_data;
    wr_data[col_q] = on_q;
  end

  always_comb begin
    dev_d    = dev_q;
    reg_d    = reg_q;
    row_d    = row_q;
    ovalid_d = ovalid_q & ~out_ready_i;
    oword_d  = oword_q;
    done     = 1'b0;
    case (ctrl.op)
      OP_INIT_EMIT: begin
        if (emit_ok) begin
          ovalid_d = 1'b1;
          oword_d  = '{frame: init_frame, last: 1'b0};
          if (dev_q == DEV_W'(NUM_DEVICES - 1)) begin
            dev_d = '0;
            if (reg_q == INIT_DECODE) begin
              reg_d = INIT_TEST;
              done  = 1'b1;
            end else begin
              reg_d = init_reg_e'(reg_q + 3'd1);
            end
          end else begin
            dev_d = dev_q + 1'b1;
          end
        end
      end
      OP_ROW_EMIT: begin
        if (emit_ok) begin
          ovalid_d = 1'b1;
          oword_d  = '{frame: row_frame, last: (row_q == ROW_AW'(NUM_ROWS - 1))};
          row_d    = row_q + 1'b1;
          done     = (row_q == ROW_AW'(NUM_ROWS - 1));
        end
      end
      default: begin
      end
    endcase
    rd_addr = (ctrl.op == OP_PIX_RD) ? py_q : row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= 4'd0;
      scan_q      <= 3'd7;
      dev_q       <= '0;
      reg_q       <= INIT_TEST;
      row_q       <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      dev_q    <= dev_d;
      reg_q    <= reg_d;
      row_q    <= row_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_INTENSITY:  intensity_q <= cfg_data_i[3:0];
          CFG_SCAN_LIMIT: scan_q      <= cfg_data_i[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    oword_q <= oword_d;
    if (ctrl.accept) begin
      col_q <= COL_W'(ROW_W - 1) - in_word_i.pixel_x[COL_W-1:0];
      py_q  <= in_word_i.pixel_y[ROW_AW-1:0];
      on_q  <= in_word_i.pixel_on;
    end
  end

endmodule
